// ===== rtl/srarq_pkg.sv =====
// Shared types and constants of the selective-repeat ARQ sender.
package srarq_pkg;

    localparam int MAX_PACKETS = 4096;
    localparam int WINDOW      = 40;

    localparam int IDX_W    = $clog2(MAX_PACKETS);
    localparam int CNT_W    = 13;
    localparam int SEQ_W    = 16;
    localparam int RETRY_W  = 4;
    localparam int WIN_W    = 6;
    localparam int STATUS_W = RETRY_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WINDOW = 2'd2;

    localparam logic [CNT_W-1:0]   TOTAL_RESET = '0;
    localparam logic [RETRY_W-1:0] LIMIT_RESET = RETRY_W'(10);
    localparam logic [WIN_W-1:0]   WIN_RESET   = WIN_W'(WINDOW);

    typedef enum logic [1:0] {
        KIND_PUMP    = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_NAK     = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_FILL,
        ST_NAK,
        ST_TO_RD,
        ST_TO_EV,
        ST_STATUS
    } state_t;

endpackage

// ===== rtl/srarq_cmd_if.sv =====
// Input channel of the ARQ sender: one event item per handshake.
interface srarq_cmd_if
    import srarq_pkg::*;
();
    logic             valid;
    logic             ready;
    kind_t            kind;
    logic [SEQ_W-1:0] seq;

    modport source (output valid, output kind, output seq, input ready);
    modport sink   (input valid, input kind, input seq, output ready);
endinterface

// ===== rtl/srarq_res_if.sv =====
// Output channel of the ARQ sender: transmit commands and status items.
interface srarq_res_if
    import srarq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             is_send;
    logic [SEQ_W-1:0] packet_seq;
    logic             is_retry;
    logic [CNT_W-1:0] window_base;
    logic             all_done;
    logic             last;

    modport source (output valid, output is_send, output packet_seq, output is_retry,
                    output window_base, output all_done, output last, input ready);
    modport sink   (input valid, input is_send, input packet_seq, input is_retry,
                    input window_base, input all_done, input last, output ready);
endinterface

// ===== rtl/srarq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srarq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/selective_repeat_arq_sender.sv =====
// Selective-repeat ARQ sender: transmit scheduler over a per-packet status memory.
//
// cmd carries one event item (pump, ack, nak, timeout with its sequence number).
// res carries zero or more transmit commands followed by one status item with
// last set. cfg_we/cfg_index/cfg_data write total_packets, retry_limit and
// active_window; write them only while the block is idle.
// Per-packet acked bit and retry count sit in a 4096 x 5 memory with
// registered read data; every walk issues one read per cycle while res is
// not stalled, so the walk rate is set by that read port.
// Work per item:
//   pump     sends new packets while the window and total_packets allow
//   ack      marks the packet acked, advances base over acked packets, then
//            sends new packets as pump does (an unknown ack marks nothing)
//   nak      resends the named packet (nothing if the sequence is unknown)
//   timeout  retries unacked packets in [base, next), at most 40 in the window
// cmd.ready is high only between items. After reset a clearing pass
// zeroes all 4096 status memory entries; no item is taken until it ends.
// res is a single output register: while res stalls, the timeout walk holds in
// place (the memory read data is held) and resumes when the item is taken.
module selective_repeat_arq_sender
    import srarq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    srarq_cmd_if.sink             cmd,
    srarq_res_if.source           res
);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_PACKETS);
    localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(MAX_PACKETS - 1);
    localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(WINDOW);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   total_reg;
    logic [RETRY_W-1:0] limit_reg;
    logic [WIN_W-1:0]   win_reg;

    logic [CNT_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0] next_reg, next_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic             res_valid_reg;
    logic             res_send_reg;
    logic [SEQ_W-1:0] res_seq_reg;
    logic             res_retry_reg;
    logic [CNT_W-1:0] res_base_reg;
    logic             res_done_reg;
    logic             res_last_reg;

    logic             emit;
    logic             emit_send;
    logic [SEQ_W-1:0] emit_seq;
    logic             emit_retry;
    logic             emit_last;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [STATUS_W-1:0] mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    logic [STATUS_W-1:0] mem_rdata;

    logic [CNT_W-1:0]    eff_count;
    logic [WIN_W-1:0]    eff_win;
    logic [CNT_W:0]      fill_lim;
    logic                can_fill;
    logic [SEQ_W-1:0]    cmd_seq_m1;
    logic                cmd_known;
    logic                cmd_accept;
    logic                slot_free;
    logic                acked;
    logic [RETRY_W-1:0]  rcnt;
    logic [STATUS_W-1:0] bumped;
    logic                need_retry;
    logic [CNT_W-1:0]    base_inc;
    logic [CNT_W-1:0]    ptr_inc;
    logic                base_walk_ok;
    logic                inc_walk_ok;
    logic                to_first_ok;
    logic                to_more;

    srarq_ram #(
        .WIDTH (STATUS_W),
        .DEPTH (MAX_PACKETS)
    ) u_status_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared conditions
    assign eff_count  = (total_reg > MAX_CNT) ? MAX_CNT : total_reg;
    assign eff_win    = (win_reg == '0) ? WIN_W'(1) : ((win_reg > WIN_MAX) ? WIN_MAX : win_reg);
    assign fill_lim   = {1'b0, base_reg} + (CNT_W+1)'(eff_win);
    assign can_fill   = ({1'b0, next_reg} < fill_lim) && (next_reg < eff_count);
    assign cmd_seq_m1 = cmd.seq - SEQ_W'(1);
    assign cmd_known  = (cmd.seq != '0) && (cmd_seq_m1 < SEQ_W'(eff_count));
    assign cmd_accept = cmd.valid && cmd.ready;
    assign slot_free  = !res_valid_reg || res.ready;

    assign acked      = mem_rdata[STATUS_W-1];
    assign rcnt       = mem_rdata[RETRY_W-1:0];
    assign bumped     = (rcnt == '1) ? mem_rdata : mem_rdata + STATUS_W'(1);
    assign need_retry = !acked && (rcnt < limit_reg);

    assign base_inc     = base_reg + CNT_W'(1);
    assign ptr_inc      = ptr_reg + CNT_W'(1);
    assign base_walk_ok = (base_reg < eff_count) && (base_reg < next_reg);
    assign inc_walk_ok  = (base_inc < eff_count) && (base_inc < next_reg);
    assign to_first_ok  = (base_reg < next_reg) && (base_reg < MAX_CNT);
    assign to_more      = (ptr_inc < next_reg) && (ptr_inc < MAX_CNT);

    assign cmd.ready = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (ptr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    case (cmd.kind)
                        KIND_PUMP:    state_next = ST_FILL;
                        KIND_ACK:
                        begin
                            if (cmd_known && (cmd_seq_m1 < SEQ_W'(next_reg)))
                            begin
                                state_next = ST_MARK;
                            end
                            else
                            begin
                                state_next = ST_WALK_RD;
                            end
                        end
                        KIND_NAK:     state_next = cmd_known ? ST_NAK : ST_STATUS;
                        KIND_TIMEOUT: state_next = ST_TO_RD;
                        default:      state_next = ST_STATUS;
                    endcase
                end
            end
            ST_MARK:    state_next = ST_WALK_RD;
            ST_WALK_RD: state_next = base_walk_ok ? ST_WALK_EV : ST_FILL;
            ST_WALK_EV:
            begin
                if (!acked || !inc_walk_ok)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (!can_fill)
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_NAK:
            begin
                if (slot_free)
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_TO_RD:   state_next = to_first_ok ? ST_TO_EV : ST_STATUS;
            ST_TO_EV:
            begin
                if ((!need_retry || slot_free) && !to_more)
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath, memory control and result emission
    always_comb
    begin
        base_next  = base_reg;
        next_next  = next_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = bumped;
        mem_re     = 1'b0;
        mem_raddr  = idx_reg;
        emit       = 1'b0;
        emit_send  = 1'b1;
        emit_seq   = '0;
        emit_retry = 1'b0;
        emit_last  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[IDX_W-1:0];
                mem_wdata = '0;
                ptr_next  = ptr_inc;
            end
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    idx_next  = cmd_seq_m1[IDX_W-1:0];
                    ptr_next  = base_reg;
                    mem_raddr = cmd_seq_m1[IDX_W-1:0];
                    mem_re    = ((cmd.kind == KIND_ACK) || (cmd.kind == KIND_NAK)) && cmd_known;
                end
            end
            ST_MARK:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata | {1'b1, {RETRY_W{1'b0}}};
            end
            ST_WALK_RD:
            begin
                mem_raddr = base_reg[IDX_W-1:0];
                mem_re    = base_walk_ok;
            end
            ST_WALK_EV:
            begin
                mem_raddr = base_inc[IDX_W-1:0];
                if (acked)
                begin
                    base_next = base_inc;
                    mem_re    = inc_walk_ok;
                end
            end
            ST_FILL:
            begin
                if (can_fill && slot_free)
                begin
                    emit      = 1'b1;
                    emit_seq  = SEQ_W'(next_reg) + SEQ_W'(1);
                    next_next = next_reg + CNT_W'(1);
                end
            end
            ST_NAK:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_seq   = SEQ_W'(idx_reg) + SEQ_W'(1);
                    emit_retry = 1'b1;
                    mem_we     = 1'b1;
                end
            end
            ST_TO_RD:
            begin
                mem_raddr = ptr_reg[IDX_W-1:0];
                mem_re    = to_first_ok;
            end
            ST_TO_EV:
            begin
                mem_waddr = ptr_reg[IDX_W-1:0];
                mem_raddr = ptr_inc[IDX_W-1:0];
                if (!need_retry || slot_free)
                begin
                    emit       = need_retry;
                    emit_seq   = SEQ_W'(ptr_reg) + SEQ_W'(1);
                    emit_retry = 1'b1;
                    mem_we     = need_retry;
                    mem_re     = to_more;
                    ptr_next   = ptr_inc;
                end
            end
            ST_STATUS:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_send = 1'b0;
                    emit_last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            total_reg     <= TOTAL_RESET;
            limit_reg     <= LIMIT_RESET;
            win_reg       <= WIN_RESET;
            base_reg      <= '0;
            next_reg      <= '0;
            ptr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            next_reg  <= next_next;
            ptr_reg   <= ptr_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TOTAL_PACKETS: total_reg <= cfg_data;
                    CFG_RETRY_LIMIT:   limit_reg <= cfg_data[RETRY_W-1:0];
                    CFG_ACTIVE_WINDOW: win_reg   <= cfg_data[WIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (emit)
        begin
            res_send_reg  <= emit_send;
            res_seq_reg   <= emit_seq;
            res_retry_reg <= emit_retry;
            res_base_reg  <= base_reg;
            res_done_reg  <= (base_reg >= eff_count);
            res_last_reg  <= emit_last;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.is_send     = res_send_reg;
    assign res.packet_seq  = res_seq_reg;
    assign res.is_retry    = res_retry_reg;
    assign res.window_base = res_base_reg;
    assign res.all_done    = res_done_reg;
    assign res.last        = res_last_reg;
endmodule

// ===== rtl/srarq_checker.sv =====
// Port-level assertions for the ARQ sender, bound to the top level.
module srarq_checker
    import srarq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_valid,
    input logic             cmd_ready,
    input logic             res_valid,
    input logic             res_ready,
    input logic             res_is_send,
    input logic [SEQ_W-1:0] res_packet_seq,
    input logic             res_is_retry,
    input logic             res_last
);
    // a stalled item holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            res_valid && $stable(res_packet_seq) && $stable(res_last) && $stable(res_is_send))
        else $error("res item changed while stalled");

    // the status item closes an event and carries no sequence
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_is_send |-> res_last && (res_packet_seq == '0) && !res_is_retry)
        else $error("malformed status item");

    a_send_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_is_send |-> !res_last && (res_packet_seq != '0))
        else $error("malformed transmit item");

    // one event at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("cmd taken back to back");
endmodule

bind selective_repeat_arq_sender srarq_checker u_srarq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_is_send    (res.is_send),
    .res_packet_seq (res.packet_seq),
    .res_is_retry   (res.is_retry),
    .res_last       (res.last)
);
